>>> design/tracker_record_deframer_assert.svh
// ---------------------------------------------------------------------------
// tracker record deframer assertion macros
// shared property wrappers for the deframer rtl
// ---------------------------------------------------------------------------
`ifndef TRACKER_RECORD_DEFRAMER_ASSERT_SVH
`define TRACKER_RECORD_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define TRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define TRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> design/trd_pkg.sv
// ---------------------------------------------------------------------------
// trd_pkg
// shared types and constants of the tracker record deframer
// ---------------------------------------------------------------------------
package trd_pkg;

    localparam int BYTE_W           = 8;
    localparam int LOW_W            = 7;
    localparam int WORD_W           = 16;
    localparam int IDX_W            = 3;
    localparam int WORDS_PER_RECORD = 6;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS_PER_RECORD - 1);
    localparam logic [IDX_W-1:0] Z_IDX    = 3'd2;
    localparam logic [IDX_W-1:0] ANG_IDX  = 3'd3;

    localparam int POS_W = 12;
    localparam int ANG_W = 21;
    localparam int VAL_W = 21;

    localparam int MAG_W       = 16;
    localparam int RCP_W       = 21;
    localparam int SCL_W       = 20;
    localparam int DIV_W       = 19;
    localparam int RCP_SHIFT   = 16;
    localparam int PRODQ_W     = MAG_W + RCP_W;
    localparam int PRODP_W     = MAG_W + SCL_W;
    localparam int Q_W         = 21;
    localparam int PRODM_W     = Q_W + DIV_W;
    localparam int REM_W       = DIV_W + 1;

    // reciprocal scales, floor(scale * 2^16 / divisor)
    localparam logic [RCP_W-1:0] RCP_POS_SHORT = 21'd1828;
    localparam logic [RCP_W-1:0] RCP_POS_LONG  = 21'd3657;
    localparam logic [RCP_W-1:0] RCP_ANG       = 21'd1296039;

    localparam logic [SCL_W-1:0] SCL_POS_SHORT = 20'd9144;
    localparam logic [SCL_W-1:0] SCL_POS_LONG  = 20'd18288;
    localparam logic [SCL_W-1:0] SCL_ANG       = 20'd648000;

    localparam logic [DIV_W-1:0] DIV_POS = 19'd327670;
    localparam logic [DIV_W-1:0] DIV_ANG = 19'd32767;

    localparam logic [ANG_W-1:0] FULL_TURN = 21'd1296000;

    localparam int REC_W      = 3 * POS_W + 3 * ANG_W;
    localparam int OUT_DATA_W = ((REC_W + 7) / 8) * 8;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  idx;
        logic              rng;
    } t_word_item;

endpackage

>>> design/tracker_record_deframer.sv
// a record enters the output register after its last word passes the queue and s1 to s4
// throughput: one byte per cycle while the word queue has room; the converter pipeline
// accepts one word per cycle; a full output register stalls it and the word queue fills
// reset: synchronous active-low i_rst_n clears framing state, queue and valid flags
// after reset the deframer drops bytes until a start byte arrives; range select is 0
// ---------------------------------------------------------------------------
// tracker_record_deframer
// deframes six-word position/angle records from a tracker byte stream
// ---------------------------------------------------------------------------
module tracker_record_deframer #(
    parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,    // range_select
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [trd_pkg::BYTE_W-1:0]      i_s_axis_tdata,   // rx_byte
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // x_mm, y_mm, z_mm, yaw_arcsec, pitch_arcsec, roll_arcsec, zero pad
    output logic [trd_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    logic                       w_push;
    trd_pkg::t_word_item        w_push_item;
    logic                       w_full;
    logic                       w_q_valid;
    trd_pkg::t_word_item        w_q_item;
    logic                       w_pop;
    logic [trd_pkg::REC_W-1:0]  w_rec;

    trd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte_vld    (i_s_axis_tvalid),
        .i_byte        (i_s_axis_tdata),
        .i_full        (w_full),
        .o_byte_rdy    (o_s_axis_tready),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    trd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    trd_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_pop),
        .o_rec_valid (o_m_axis_tvalid),
        .i_rec_ready (i_m_axis_tready),
        .o_rec       (w_rec)
    );

    assign o_m_axis_tdata = trd_pkg::OUT_DATA_W'(w_rec);

endmodule

>>> design/trd_front.sv
// ---------------------------------------------------------------------------
// trd_front
// byte framer: tracks record start, pairs 7-bit bytes into words
// ---------------------------------------------------------------------------
`include "tracker_record_deframer_assert.svh"

module trd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    input  logic                       i_byte_vld,
    input  logic [trd_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_full,
    output logic                       o_byte_rdy,
    output logic                       o_push,
    output trd_pkg::t_word_item        o_item
);

    logic                        r_range_sel;
    logic                        r_wait_start;
    logic                        r_have_low;
    logic [trd_pkg::IDX_W-1:0]   r_idx;
    logic [trd_pkg::LOW_W-1:0]   r_low;
    logic                        w_acc;
    logic                        w_start;

    assign o_byte_rdy = !i_full;
    assign w_acc      = i_byte_vld && !i_full;
    assign w_start    = i_byte[trd_pkg::BYTE_W-1];

    assign o_push      = w_acc && !w_start && !r_wait_start && r_have_low;
    assign o_item.word = {i_byte[trd_pkg::LOW_W-1:0], r_low, 2'b00};
    assign o_item.idx  = r_idx;
    assign o_item.rng  = r_range_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_sel  <= 1'b0;
            r_wait_start <= 1'b1;
            r_have_low   <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_range_sel <= i_cfg_wr_data;
            end
            if (w_acc) begin
                if (w_start) begin
                    r_wait_start <= 1'b0;
                    r_idx        <= '0;
                    r_have_low   <= 1'b1;
                end else if (!r_wait_start) begin
                    if (!r_have_low) begin
                        r_have_low <= 1'b1;
                    end else begin
                        r_have_low <= 1'b0;
                        if (r_idx == trd_pkg::LAST_IDX) begin
                            r_wait_start <= 1'b1;
                            r_idx        <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (w_start || (!r_wait_start && !r_have_low))) begin
            r_low <= i_byte[trd_pkg::LOW_W-1:0];
        end
    end

    `TRD_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, o_push, !i_full)

endmodule

>>> design/trd_queue.sv
// ---------------------------------------------------------------------------
// trd_queue
// small word queue between framer and converter
// ---------------------------------------------------------------------------
`include "tracker_record_deframer_assert.svh"

module trd_queue #(
    parameter int DEPTH = trd_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  trd_pkg::t_word_item i_item,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output trd_pkg::t_word_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    trd_pkg::t_word_item r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `TRD_ASSERT_IMPL(a_q_pop_not_empty, i_clk, i_rst_n, i_pop, r_count != '0)
    `TRD_ASSERT_NEXT(a_q_idle_holds, i_clk, i_rst_n, !i_push && !i_pop, $stable(r_count))

endmodule

>>> design/trd_conv.sv
// ---------------------------------------------------------------------------
// trd_conv
// word converter pipeline and record assembly with output register
// ---------------------------------------------------------------------------
`include "tracker_record_deframer_assert.svh"

module trd_conv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  trd_pkg::t_word_item            i_q_item,
    output logic                           o_q_pop,
    output logic                           o_rec_valid,
    input  logic                           i_rec_ready,
    output logic [trd_pkg::REC_W-1:0]      o_rec
);

    localparam int MAG_W   = trd_pkg::MAG_W;
    localparam int IDX_W   = trd_pkg::IDX_W;
    localparam int Q_W     = trd_pkg::Q_W;
    localparam int VAL_W   = trd_pkg::VAL_W;
    localparam int POS_W   = trd_pkg::POS_W;
    localparam int ANG_W   = trd_pkg::ANG_W;
    localparam int PRODQ_W = trd_pkg::PRODQ_W;
    localparam int PRODP_W = trd_pkg::PRODP_W;
    localparam int PRODM_W = trd_pkg::PRODM_W;
    localparam int REM_W   = trd_pkg::REM_W;

    logic w_en;

    // stage 0 to 1: sign and magnitude
    logic             w_neg0;
    logic [MAG_W-1:0] w_mag0;
    logic             r_s1_vld;
    logic             r_s1_neg;
    logic             r_s1_rng;
    logic [IDX_W-1:0] r_s1_idx;
    logic [MAG_W-1:0] r_s1_mag;

    // stage 1 to 2: scaled products
    logic                        w_ang1;
    logic [trd_pkg::RCP_W-1:0]   w_rcp1;
    logic [trd_pkg::SCL_W-1:0]   w_scl1;
    logic [PRODQ_W-1:0]          w_prodq1;
    logic                        r_s2_vld;
    logic                        r_s2_neg;
    logic [IDX_W-1:0]            r_s2_idx;
    logic [Q_W-1:0]              r_s2_q0;
    logic [PRODP_W-1:0]          r_s2_p;

    // stage 2 to 3: quotient back-multiply
    logic [trd_pkg::DIV_W-1:0]   w_div2;
    logic                        r_s3_vld;
    logic                        r_s3_neg;
    logic [IDX_W-1:0]            r_s3_idx;
    logic [Q_W-1:0]              r_s3_q0;
    logic [PRODP_W-1:0]          r_s3_p;
    logic [PRODM_W-1:0]          r_s3_m;

    // stage 3 to 4: correction and sign fixup
    logic [trd_pkg::DIV_W-1:0]   w_div3;
    logic [REM_W-1:0]            w_div3_x;
    logic [PRODM_W-1:0]          w_diff3;
    logic [REM_W-1:0]            w_rem3;
    logic                        w_ge3;
    logic                        w_exact3;
    logic [Q_W-1:0]              w_q3;
    logic [VAL_W-1:0]            w_val3;
    logic                        r_s4_vld;
    logic [IDX_W-1:0]            r_s4_idx;
    logic [VAL_W-1:0]            r_s4_val;

    // record assembly
    logic [VAL_W-1:0]            r_vals [trd_pkg::WORDS_PER_RECORD - 1];
    logic                        r_out_valid;
    logic [trd_pkg::REC_W-1:0]   r_out;

    assign w_en    = !(r_out_valid && !i_rec_ready);
    assign o_q_pop = i_q_valid && w_en;

    assign w_neg0 = i_q_item.word[trd_pkg::WORD_W-1];
    assign w_mag0 = w_neg0 ? (~i_q_item.word + 1'b1) : i_q_item.word;

    always_comb begin
        w_ang1 = (r_s1_idx >= trd_pkg::ANG_IDX);
        if (w_ang1) begin
            w_rcp1 = trd_pkg::RCP_ANG;
            w_scl1 = trd_pkg::SCL_ANG;
        end else if (r_s1_rng) begin
            w_rcp1 = trd_pkg::RCP_POS_LONG;
            w_scl1 = trd_pkg::SCL_POS_LONG;
        end else begin
            w_rcp1 = trd_pkg::RCP_POS_SHORT;
            w_scl1 = trd_pkg::SCL_POS_SHORT;
        end
        w_prodq1 = PRODQ_W'(r_s1_mag) * PRODQ_W'(w_rcp1);
    end

    assign w_div2 = (r_s2_idx >= trd_pkg::ANG_IDX) ? trd_pkg::DIV_ANG : trd_pkg::DIV_POS;

    always_comb begin
        w_div3   = (r_s3_idx >= trd_pkg::ANG_IDX) ? trd_pkg::DIV_ANG : trd_pkg::DIV_POS;
        w_div3_x = REM_W'(w_div3);
        w_diff3  = PRODM_W'(r_s3_p) - r_s3_m;
        w_rem3   = w_diff3[REM_W-1:0];
        w_ge3    = (w_rem3 >= w_div3_x);
        w_exact3 = (w_rem3 == '0) || (w_rem3 == w_div3_x);
        w_q3     = r_s3_q0 + Q_W'(w_ge3);
        if (r_s3_idx >= trd_pkg::ANG_IDX) begin
            w_val3 = r_s3_neg ? (trd_pkg::FULL_TURN - w_q3 - Q_W'(!w_exact3)) : w_q3;
        end else begin
            w_val3 = (r_s3_neg ^ (r_s3_idx == trd_pkg::Z_IDX)) ? (~w_q3 + 1'b1) : w_q3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_s1_vld <= o_q_pop;
                r_s2_vld <= r_s1_vld;
                r_s3_vld <= r_s2_vld;
                r_s4_vld <= r_s3_vld;
            end
            if (w_en && r_s4_vld && (r_s4_idx == trd_pkg::LAST_IDX)) begin
                r_out_valid <= 1'b1;
            end else if (i_rec_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_neg <= w_neg0;
            r_s1_rng <= i_q_item.rng;
            r_s1_idx <= i_q_item.idx;
            r_s1_mag <= w_mag0;

            r_s2_neg <= r_s1_neg;
            r_s2_idx <= r_s1_idx;
            r_s2_q0  <= w_prodq1[trd_pkg::RCP_SHIFT +: Q_W];
            r_s2_p   <= PRODP_W'(r_s1_mag) * PRODP_W'(w_scl1);

            r_s3_neg <= r_s2_neg;
            r_s3_idx <= r_s2_idx;
            r_s3_q0  <= r_s2_q0;
            r_s3_p   <= r_s2_p;
            r_s3_m   <= PRODM_W'(r_s2_q0) * PRODM_W'(w_div2);

            r_s4_idx <= r_s3_idx;
            r_s4_val <= w_val3;

            if (r_s4_vld) begin
                if (r_s4_idx == trd_pkg::LAST_IDX) begin
                    r_out <= {r_s4_val[ANG_W-1:0], r_vals[4][ANG_W-1:0],
                              r_vals[3][ANG_W-1:0], r_vals[2][POS_W-1:0],
                              r_vals[1][POS_W-1:0], r_vals[0][POS_W-1:0]};
                end else begin
                    r_vals[r_s4_idx] <= r_s4_val;
                end
            end
        end
    end

    assign o_rec_valid = r_out_valid;
    assign o_rec       = r_out;

    `TRD_ASSERT_NEXT(a_last_word_loads_out, i_clk, i_rst_n,
        r_s4_vld && w_en && (r_s4_idx == trd_pkg::LAST_IDX), r_out_valid)

endmodule
